// ----- rtl/irrd_pkg.sv -----
package irrd_pkg;

	localparam int TIMER_WIDTH = 16;
	localparam int SCALE_W     = 17;
	localparam int PROD_W      = TIMER_WIDTH + SCALE_W;
	// quotient bits resolved by the divider chain, enough for the largest window bound
	localparam int RATIO_W     = 13;
	localparam int HI_W        = PROD_W - RATIO_W;
	localparam int STEP_SH     = 3;
	localparam int IDX_W       = RATIO_W - STEP_SH;
	localparam int S0_IDX_W    = 9;
	localparam int CM_W        = 8;
	localparam int DIST_W      = 12;

	localparam logic [SCALE_W-1:0] RATIO_SCALE = 17'd100000;

	localparam logic [RATIO_W-1:0] S180_MAX = 13'd5400;
	localparam logic [RATIO_W-1:0] S180_MIN = 13'd920;
	localparam logic [RATIO_W-1:0] S0_MAX   = 13'd4500;
	localparam logic [RATIO_W-1:0] S0_MIN   = 13'd820;
	localparam logic [IDX_W-1:0]   S180_LAST = 10'd560;
	localparam logic [IDX_W-1:0]   S0_LAST   = 10'd460;

	localparam logic SENSOR_S180 = 1'b0;
	localparam logic SENSOR_S0   = 1'b1;

	typedef struct packed {
		logic                   sensor_select;
		logic [TIMER_WIDTH-1:0] pulse_width;
		logic [TIMER_WIDTH-1:0] rotation_period;
	} sample_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance_mm;
		logic              period_zero;
	} result_t;

	// state handed from one divider cell to the next
	typedef struct packed {
		logic [TIMER_WIDTH-1:0] rem;
		logic [RATIO_W-1:0]     low;
		logic [RATIO_W-1:0]     quo;
		logic [TIMER_WIDTH-1:0] divisor;
		logic                   sensor_select;
		logic                   period_zero;
		logic                   sat;
	} divstep_t;

	localparam logic [CM_W-1:0] ROM_S180 [0:560] = '{
		8'd23,8'd23,8'd24,8'd24,8'd25,8'd25,8'd26,8'd27,8'd27,8'd28,
		8'd28,8'd29,8'd29,8'd30,8'd30,8'd31,8'd32,8'd32,8'd33,8'd33,
		8'd34,8'd34,8'd35,8'd36,8'd36,8'd37,8'd37,8'd38,8'd38,8'd39,
		8'd40,8'd40,8'd41,8'd41,8'd42,8'd42,8'd43,8'd44,8'd44,8'd45,
		8'd45,8'd46,8'd46,8'd47,8'd48,8'd48,8'd49,8'd49,8'd50,8'd50,
		8'd51,8'd51,8'd52,8'd53,8'd53,8'd54,8'd54,8'd55,8'd55,8'd56,
		8'd56,8'd57,8'd57,8'd58,8'd58,8'd59,8'd60,8'd60,8'd61,8'd61,
		8'd62,8'd62,8'd63,8'd63,8'd64,8'd64,8'd65,8'd65,8'd66,8'd66,
		8'd67,8'd67,8'd68,8'd68,8'd69,8'd69,8'd69,8'd70,8'd70,8'd71,
		8'd71,8'd72,8'd72,8'd73,8'd73,8'd74,8'd74,8'd74,8'd75,8'd75,
		8'd76,8'd76,8'd77,8'd77,8'd77,8'd78,8'd78,8'd79,8'd79,8'd79,
		8'd80,8'd80,8'd81,8'd81,8'd81,8'd82,8'd82,8'd83,8'd83,8'd83,
		8'd84,8'd84,8'd84,8'd85,8'd85,8'd86,8'd86,8'd86,8'd87,8'd87,
		8'd87,8'd88,8'd88,8'd88,8'd89,8'd89,8'd89,8'd90,8'd90,8'd90,
		8'd91,8'd91,8'd91,8'd92,8'd92,8'd92,8'd93,8'd93,8'd93,8'd93,
		8'd94,8'd94,8'd94,8'd95,8'd95,8'd95,8'd96,8'd96,8'd96,8'd96,
		8'd97,8'd97,8'd97,8'd98,8'd98,8'd98,8'd98,8'd99,8'd99,8'd99,
		8'd99,8'd100,8'd100,8'd100,8'd101,8'd101,8'd101,8'd101,8'd102,8'd102,
		8'd102,8'd102,8'd103,8'd103,8'd103,8'd103,8'd104,8'd104,8'd104,8'd104,
		8'd105,8'd105,8'd105,8'd105,8'd106,8'd106,8'd106,8'd106,8'd107,8'd107,
		8'd107,8'd107,8'd108,8'd108,8'd108,8'd108,8'd109,8'd109,8'd109,8'd109,
		8'd110,8'd110,8'd110,8'd110,8'd111,8'd111,8'd111,8'd111,8'd112,8'd112,
		8'd112,8'd112,8'd113,8'd113,8'd113,8'd113,8'd114,8'd114,8'd114,8'd114,
		8'd115,8'd115,8'd115,8'd115,8'd116,8'd116,8'd116,8'd116,8'd117,8'd117,
		8'd117,8'd117,8'd118,8'd118,8'd118,8'd119,8'd119,8'd119,8'd119,8'd120,
		8'd120,8'd120,8'd120,8'd121,8'd121,8'd121,8'd122,8'd122,8'd122,8'd122,
		8'd123,8'd123,8'd123,8'd124,8'd124,8'd124,8'd124,8'd125,8'd125,8'd125,
		8'd126,8'd126,8'd126,8'd127,8'd127,8'd127,8'd127,8'd128,8'd128,8'd128,
		8'd129,8'd129,8'd129,8'd130,8'd130,8'd130,8'd131,8'd131,8'd131,8'd132,
		8'd132,8'd132,8'd133,8'd133,8'd133,8'd134,8'd134,8'd134,8'd135,8'd135,
		8'd135,8'd136,8'd136,8'd136,8'd137,8'd137,8'd137,8'd138,8'd138,8'd138,
		8'd139,8'd139,8'd139,8'd140,8'd140,8'd141,8'd141,8'd141,8'd142,8'd142,
		8'd142,8'd143,8'd143,8'd143,8'd144,8'd144,8'd145,8'd145,8'd145,8'd146,
		8'd146,8'd147,8'd147,8'd147,8'd148,8'd148,8'd148,8'd149,8'd149,8'd150,
		8'd150,8'd150,8'd151,8'd151,8'd152,8'd152,8'd152,8'd153,8'd153,8'd154,
		8'd154,8'd154,8'd155,8'd155,8'd156,8'd156,8'd156,8'd157,8'd157,8'd158,
		8'd158,8'd158,8'd159,8'd159,8'd160,8'd160,8'd161,8'd161,8'd161,8'd162,
		8'd162,8'd163,8'd163,8'd163,8'd164,8'd164,8'd165,8'd165,8'd166,8'd166,
		8'd166,8'd167,8'd167,8'd168,8'd168,8'd168,8'd169,8'd169,8'd170,8'd170,
		8'd170,8'd171,8'd171,8'd172,8'd172,8'd173,8'd173,8'd173,8'd174,8'd174,
		8'd175,8'd175,8'd175,8'd176,8'd176,8'd177,8'd177,8'd177,8'd178,8'd178,
		8'd179,8'd179,8'd179,8'd180,8'd180,8'd181,8'd181,8'd181,8'd182,8'd182,
		8'd183,8'd183,8'd183,8'd184,8'd184,8'd184,8'd185,8'd185,8'd186,8'd186,
		8'd186,8'd187,8'd187,8'd187,8'd188,8'd188,8'd189,8'd189,8'd189,8'd190,
		8'd190,8'd190,8'd191,8'd191,8'd191,8'd192,8'd192,8'd192,8'd193,8'd193,
		8'd194,8'd194,8'd194,8'd195,8'd195,8'd195,8'd196,8'd196,8'd196,8'd197,
		8'd197,8'd197,8'd197,8'd198,8'd198,8'd198,8'd199,8'd199,8'd199,8'd200,
		8'd200,8'd200,8'd201,8'd201,8'd201,8'd201,8'd202,8'd202,8'd202,8'd203,
		8'd203,8'd203,8'd203,8'd204,8'd204,8'd204,8'd204,8'd205,8'd205,8'd205,
		8'd205,8'd206,8'd206,8'd206,8'd207,8'd207,8'd207,8'd207,8'd207,8'd208,
		8'd208,8'd208,8'd208,8'd209,8'd209,8'd209,8'd209,8'd210,8'd210,8'd210,
		8'd210,8'd211,8'd211,8'd211,8'd211,8'd211,8'd212,8'd212,8'd212,8'd212,
		8'd212,8'd213,8'd213,8'd213,8'd213,8'd214,8'd214,8'd214,8'd214,8'd214,
		8'd215,8'd215,8'd215,8'd215,8'd215,8'd216,8'd216,8'd216,8'd216,8'd216,
		8'd217,8'd217,8'd217,8'd217,8'd217,8'd218,8'd218,8'd218,8'd218,8'd219,
		8'd219,8'd219,8'd219,8'd219,8'd220,8'd220,8'd220,8'd220,8'd221,8'd221,
		8'd221
	};

	localparam logic [CM_W-1:0] ROM_S0 [0:460] = '{
		8'd30,8'd30,8'd30,8'd30,8'd30,8'd30,8'd30,8'd30,8'd30,8'd30,
		8'd30,8'd30,8'd30,8'd31,8'd31,8'd31,8'd31,8'd31,8'd31,8'd31,
		8'd31,8'd31,8'd31,8'd31,8'd31,8'd31,8'd31,8'd31,8'd32,8'd32,
		8'd32,8'd32,8'd32,8'd32,8'd32,8'd32,8'd32,8'd33,8'd33,8'd33,
		8'd33,8'd33,8'd33,8'd33,8'd33,8'd34,8'd34,8'd34,8'd34,8'd34,
		8'd34,8'd34,8'd35,8'd35,8'd35,8'd35,8'd35,8'd35,8'd36,8'd36,
		8'd36,8'd36,8'd36,8'd37,8'd37,8'd37,8'd37,8'd37,8'd38,8'd38,
		8'd38,8'd38,8'd38,8'd39,8'd39,8'd39,8'd39,8'd40,8'd40,8'd40,
		8'd40,8'd41,8'd41,8'd41,8'd41,8'd42,8'd42,8'd42,8'd42,8'd43,
		8'd43,8'd43,8'd44,8'd44,8'd44,8'd44,8'd45,8'd45,8'd45,8'd46,
		8'd46,8'd46,8'd47,8'd47,8'd47,8'd47,8'd48,8'd48,8'd48,8'd49,
		8'd49,8'd49,8'd50,8'd50,8'd50,8'd51,8'd51,8'd51,8'd52,8'd52,
		8'd53,8'd53,8'd53,8'd54,8'd54,8'd54,8'd55,8'd55,8'd56,8'd56,
		8'd56,8'd57,8'd57,8'd57,8'd58,8'd58,8'd59,8'd59,8'd59,8'd60,
		8'd60,8'd61,8'd61,8'd61,8'd62,8'd62,8'd63,8'd63,8'd64,8'd64,
		8'd64,8'd65,8'd65,8'd66,8'd66,8'd67,8'd67,8'd67,8'd68,8'd68,
		8'd69,8'd69,8'd70,8'd70,8'd71,8'd71,8'd72,8'd72,8'd72,8'd73,
		8'd73,8'd74,8'd74,8'd75,8'd75,8'd76,8'd76,8'd77,8'd77,8'd78,
		8'd78,8'd79,8'd79,8'd80,8'd80,8'd80,8'd81,8'd81,8'd82,8'd82,
		8'd83,8'd83,8'd84,8'd84,8'd85,8'd85,8'd86,8'd86,8'd87,8'd87,
		8'd88,8'd88,8'd89,8'd89,8'd90,8'd90,8'd91,8'd91,8'd92,8'd92,
		8'd93,8'd93,8'd94,8'd94,8'd95,8'd95,8'd96,8'd96,8'd97,8'd97,
		8'd98,8'd98,8'd99,8'd99,8'd100,8'd100,8'd101,8'd101,8'd102,8'd102,
		8'd103,8'd103,8'd104,8'd104,8'd105,8'd105,8'd106,8'd106,8'd107,8'd107,
		8'd108,8'd108,8'd109,8'd109,8'd110,8'd110,8'd111,8'd111,8'd112,8'd112,
		8'd113,8'd113,8'd114,8'd114,8'd115,8'd115,8'd116,8'd116,8'd117,8'd117,
		8'd118,8'd118,8'd119,8'd119,8'd120,8'd120,8'd121,8'd121,8'd122,8'd122,
		8'd123,8'd123,8'd124,8'd124,8'd125,8'd125,8'd125,8'd126,8'd126,8'd127,
		8'd127,8'd128,8'd128,8'd129,8'd129,8'd130,8'd130,8'd131,8'd131,8'd132,
		8'd132,8'd132,8'd133,8'd133,8'd134,8'd134,8'd135,8'd135,8'd136,8'd136,
		8'd137,8'd137,8'd137,8'd138,8'd138,8'd139,8'd139,8'd140,8'd140,8'd141,
		8'd141,8'd141,8'd142,8'd142,8'd143,8'd143,8'd144,8'd144,8'd144,8'd145,
		8'd145,8'd146,8'd146,8'd147,8'd147,8'd147,8'd148,8'd148,8'd149,8'd149,
		8'd149,8'd150,8'd150,8'd151,8'd151,8'd152,8'd152,8'd152,8'd153,8'd153,
		8'd154,8'd154,8'd154,8'd155,8'd155,8'd156,8'd156,8'd157,8'd157,8'd157,
		8'd158,8'd158,8'd159,8'd159,8'd159,8'd160,8'd160,8'd161,8'd161,8'd162,
		8'd162,8'd162,8'd163,8'd163,8'd164,8'd164,8'd165,8'd165,8'd165,8'd166,
		8'd166,8'd167,8'd167,8'd168,8'd168,8'd168,8'd169,8'd169,8'd170,8'd170,
		8'd171,8'd171,8'd172,8'd172,8'd173,8'd173,8'd173,8'd174,8'd174,8'd175,
		8'd175,8'd176,8'd176,8'd177,8'd177,8'd178,8'd178,8'd179,8'd179,8'd180,
		8'd180,8'd181,8'd181,8'd182,8'd183,8'd183,8'd184,8'd184,8'd185,8'd185,
		8'd186,8'd187,8'd187,8'd188,8'd188,8'd189,8'd190,8'd190,8'd191,8'd191,
		8'd192,8'd193,8'd193,8'd194,8'd195,8'd196,8'd196,8'd197,8'd198,8'd198,
		8'd199,8'd200,8'd201,8'd201,8'd202,8'd203,8'd204,8'd205,8'd205,8'd206,
		8'd207,8'd208,8'd209,8'd210,8'd211,8'd211,8'd212,8'd213,8'd214,8'd215,
		8'd216,8'd217,8'd218,8'd219,8'd220,8'd221,8'd222,8'd223,8'd224,8'd226,
		8'd227
	};

endpackage

// ----- rtl/ir_ratio_to_distance_lookup.sv -----
// Converts a beacon pulse width and rotation period into a calibrated distance.
// The ratio pulse_width * 100000 / rotation_period is found by a chain of 13
// restoring divider cells, one quotient bit per cell, after a multiply stage and
// a setup stage; a clamp/index stage and a calibration table stage follow. A new
// sample is taken every cycle as long as result_stall lets results drain; each
// stage holds its own transaction, so bubbles close up under a stall. A zero
// period yields the nearest calibrated distance with period_zero set.
module ir_ratio_to_distance_lookup import irrd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    sample_valid,
	output logic    sample_stall,
	input  sample_t sample,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	logic     chain_v [0:RATIO_W];
	logic     chain_r [0:RATIO_W];
	divstep_t chain_d [0:RATIO_W];
	logic     front_ready;

	irrd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (sample_valid),
		.up_data  (sample),
		.up_ready (front_ready),
		.dn_valid (chain_v[0]),
		.dn_data  (chain_d[0]),
		.dn_ready (chain_r[0])
	);

	assign sample_stall = !front_ready;

	for (genvar i = 0; i < RATIO_W; i++) begin : g_cell
		irrd_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (chain_v[i]),
			.up_data  (chain_d[i]),
			.up_ready (chain_r[i]),
			.dn_valid (chain_v[i+1]),
			.dn_data  (chain_d[i+1]),
			.dn_ready (chain_r[i+1])
		);
	end

	irrd_lookup u_lookup (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (chain_v[RATIO_W]),
		.up_data  (chain_d[RATIO_W]),
		.up_ready (chain_r[RATIO_W]),
		.dn_valid (result_valid),
		.dn_data  (result),
		.dn_ready (!result_stall)
	);

endmodule

// ----- rtl/irrd_front.sv -----
module irrd_front import irrd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     up_valid,
	input  sample_t  up_data,
	output logic     up_ready,
	output logic     dn_valid,
	output divstep_t dn_data,
	input  logic     dn_ready
);

	logic                   v_s1, v_s2;
	logic                   rdy_s1, rdy_s2;
	logic [PROD_W-1:0]      prod_s1;
	logic [TIMER_WIDTH-1:0] per_s1;
	logic                   sel_s1;
	divstep_t               setup;
	divstep_t               data_s2;
	logic [HI_W-1:0]        hi_part;
	logic                   zero;
	logic                   ovf;

	assign rdy_s2   = !v_s2 || dn_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign up_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= up_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) begin
			prod_s1 <= PROD_W'(up_data.pulse_width) * PROD_W'(RATIO_SCALE);
			per_s1  <= up_data.rotation_period;
			sel_s1  <= up_data.sensor_select;
		end
	end

	// quotient at or above 2^RATIO_W is beyond every window, so saturate there
	assign hi_part = prod_s1[PROD_W-1:RATIO_W];
	assign zero    = (per_s1 == '0);
	assign ovf     = (hi_part >= HI_W'(per_s1));

	always_comb begin
		setup               = '0;
		setup.rem           = prod_s1[RATIO_W+TIMER_WIDTH-1:RATIO_W];
		setup.low           = prod_s1[RATIO_W-1:0];
		setup.divisor       = per_s1;
		setup.sensor_select = sel_s1;
		setup.period_zero   = zero;
		setup.sat           = zero || ovf;
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			data_s2 <= setup;
		end
	end

	assign dn_valid = v_s2;
	assign dn_data  = data_s2;

endmodule

// ----- rtl/irrd_div_cell.sv -----
module irrd_div_cell import irrd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     up_valid,
	input  divstep_t up_data,
	output logic     up_ready,
	output logic     dn_valid,
	output divstep_t dn_data,
	input  logic     dn_ready
);

	logic                 v_q;
	divstep_t             data_q;
	divstep_t             nxt;
	logic [TIMER_WIDTH:0] trial;
	logic                 take;

	assign up_ready = !v_q || dn_ready;

	// one restoring step: bring down the next dividend bit, subtract if it fits
	assign trial = {up_data.rem, up_data.low[RATIO_W-1]};
	assign take  = (trial >= {1'b0, up_data.divisor});

	always_comb begin
		nxt     = up_data;
		nxt.rem = take ? TIMER_WIDTH'(trial - {1'b0, up_data.divisor})
		               : trial[TIMER_WIDTH-1:0];
		nxt.low = {up_data.low[RATIO_W-2:0], 1'b0};
		nxt.quo = {up_data.quo[RATIO_W-2:0], take};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (up_ready) begin
			v_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= nxt;
		end
	end

	assign dn_valid = v_q;
	assign dn_data  = data_q;

endmodule

// ----- rtl/irrd_lookup.sv -----
module irrd_lookup import irrd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     up_valid,
	input  divstep_t up_data,
	output logic     up_ready,
	output logic     dn_valid,
	output result_t  dn_data,
	input  logic     dn_ready
);

	logic               v_s1, v_s2;
	logic               rdy_s1, rdy_s2;
	logic [RATIO_W-1:0] win_hi, win_lo, clamped, offs;
	logic [IDX_W-1:0]   last, idx;
	logic [IDX_W-1:0]   idx_s1;
	logic               sel_s1, zero_s1;
	logic [CM_W-1:0]    cm;
	logic [DIST_W-1:0]  cm_w;
	result_t            res_s2;

	assign rdy_s2   = !v_s2 || dn_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign up_ready = rdy_s1;

	always_comb begin
		if (up_data.sensor_select == SENSOR_S0) begin
			win_hi = S0_MAX;
			win_lo = S0_MIN;
			last   = S0_LAST;
		end else begin
			win_hi = S180_MAX;
			win_lo = S180_MIN;
			last   = S180_LAST;
		end
		if (up_data.sat || up_data.quo > win_hi) begin
			clamped = win_hi;
		end else if (up_data.quo < win_lo) begin
			clamped = win_lo;
		end else begin
			clamped = up_data.quo;
		end
		offs = clamped - win_lo;
		// table runs from near to far, one entry per eight ratio steps
		idx  = last - offs[RATIO_W-1:STEP_SH];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= up_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) begin
			idx_s1  <= idx;
			sel_s1  <= up_data.sensor_select;
			zero_s1 <= up_data.period_zero;
		end
	end

	assign cm   = (sel_s1 == SENSOR_S0) ? ROM_S0[idx_s1[S0_IDX_W-1:0]] : ROM_S180[idx_s1];
	assign cm_w = DIST_W'(cm);

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			res_s2.distance_mm <= (cm_w << 3) + (cm_w << 1);
			res_s2.period_zero <= zero_s1;
		end
	end

	assign dn_valid = v_s2;
	assign dn_data  = res_s2;

endmodule
